// ===== hw/rtl/clad_pkg.sv =====
// -----------------------------------------------------------------------------
// clad_pkg
// shared types, character codes and helpers for the command line assembler
// -----------------------------------------------------------------------------
package clad_pkg;

   // result event codes
   typedef enum logic [1:0] {
      EV_PENDING = 2'd0,
      EV_DUMP    = 2'd1,
      EV_CHAR    = 2'd2,
      EV_UNKNOWN = 2'd3
   } event_type;

   // request mode codes
   localparam logic MODE_FEED    = 1'b0;
   localparam logic MODE_ABANDON = 1'b1;

   // character codes
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DEL    = 8'h7F;
   localparam logic [7:0] CTRL_LIMIT  = 8'h20;
   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] LOWER_Z     = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // letters of the dump keyword, upper case
   localparam logic [7:0] KEY_D = 8'h44;
   localparam logic [7:0] KEY_U = 8'h55;
   localparam logic [7:0] KEY_M = 8'h4D;
   localparam logic [7:0] KEY_P = 8'h50;

   // running keyword match over the stored line
   typedef enum logic [5:0] {
      MT_LEAD = 6'b000001,
      MT_D    = 6'b000010,
      MT_U    = 6'b000100,
      MT_M    = 6'b001000,
      MT_P    = 6'b010000,
      MT_FAIL = 6'b100000
   } match_type;

   // controller to datapath
   typedef struct packed {
      logic feed;
      logic abandon;
      logic rd_en;
      logic advance;
      logic finish;
      logic show_char;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit_line;
      logic last_char;
   } status_type;

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if ((c >= LOWER_A) && (c <= LOWER_Z)) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   // advance the match by one stored character
   function automatic match_type match_step(input match_type m, input logic [7:0] c);
      logic       blank;
      logic [7:0] up;
      match_type  r;
      blank = is_blank(c);
      up    = fold_upper(c);
      r     = MT_FAIL;
      unique case (m)
         MT_LEAD: begin
            if (blank) r = MT_LEAD;
            else if (up == KEY_D) r = MT_D;
         end
         MT_D: if (up == KEY_U) r = MT_U;
         MT_U: if (up == KEY_M) r = MT_M;
         MT_M: if (up == KEY_P) r = MT_P;
         MT_P: if (blank) r = MT_P;
         default: r = MT_FAIL;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/clad_req_if.sv =====
// -----------------------------------------------------------------------------
// clad_req_if
// request channel: mode and received byte with valid/ready
// -----------------------------------------------------------------------------
interface clad_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

// ===== hw/rtl/clad_rsp_if.sv =====
// -----------------------------------------------------------------------------
// clad_rsp_if
// result channel: event, line character and last mark with valid/ready
// -----------------------------------------------------------------------------
interface clad_rsp_if;
   logic                valid;
   logic                ready;
   clad_pkg::event_type event_res;
   logic [7:0]          line_char;
   logic                last;

   modport source (output valid, output event_res, output line_char, output last,
                   input ready);
   modport sink   (input valid, input event_res, input line_char, input last,
                   output ready);
endinterface

// ===== hw/rtl/clad_ram.sv =====
// -----------------------------------------------------------------------------
// clad_ram
// generic single write port, single read port ram with registered read
// -----------------------------------------------------------------------------
module clad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/clad_dpath.sv =====
// -----------------------------------------------------------------------------
// clad_dpath
// line store, length and overflow tracking, keyword match and result mux
// -----------------------------------------------------------------------------
module clad_dpath #(
   parameter int LINE_CAPACITY = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  clad_pkg::cmd_type    cmd,
   output clad_pkg::status_type status,
   input  logic [7:0]           req_data_byte,
   output clad_pkg::event_type  rsp_event_res,
   output logic [7:0]           rsp_line_char,
   output logic                 rsp_last
);
   import clad_pkg::*;

   localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
   localparam int ADDR_W = $clog2(LINE_CAPACITY);

   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ovf_ff, ovf_in;
   match_type         match_ff, match_in;
   event_type         ev_ff, ev_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;

   logic       line_end;
   logic       dropped;
   logic       room;
   logic       is_empty;
   logic       dump_ok;
   logic       store_en;
   logic [7:0] rd_data;

   assign line_end = (req_data_byte == CHAR_CR) || (req_data_byte == CHAR_LF);
   assign dropped  = ((req_data_byte < CTRL_LIMIT) && (req_data_byte != CHAR_TAB))
                     || (req_data_byte == CHAR_DEL);
   assign room     = len_ff < LEN_W'(LINE_CAPACITY);
   assign is_empty = len_ff == '0;
   assign dump_ok  = match_ff == MT_P;
   assign store_en = cmd.feed && !line_end && !dropped && !ovf_ff && room;

   assign status.emit_line = line_end && !ovf_ff && !is_empty && !dump_ok;
   assign status.last_char = (LEN_W'(idx_ff) + LEN_W'(1)) == len_ff;

   always_comb begin
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      match_in = match_ff;
      ev_in    = ev_ff;
      idx_in   = idx_ff;
      if (cmd.abandon || cmd.finish) begin
         len_in   = '0;
         ovf_in   = 1'b0;
         match_in = MT_LEAD;
      end else if (cmd.feed) begin
         idx_in = '0;
         ev_in  = EV_PENDING;
         if (line_end) begin
            priority if (ovf_ff) begin
               ev_in = EV_UNKNOWN;
            end else if (is_empty) begin
               ev_in = EV_PENDING;
            end else if (dump_ok) begin
               ev_in = EV_DUMP;
            end
            // a line that goes out character by character is cleared at its end
            if (!status.emit_line) begin
               len_in   = '0;
               ovf_in   = 1'b0;
               match_in = MT_LEAD;
            end
         end else if (!dropped && !ovf_ff) begin
            if (room) begin
               len_in   = len_ff + LEN_W'(1);
               match_in = match_step(match_ff, req_data_byte);
            end else begin
               len_in = '0;
               ovf_in = 1'b1;
            end
         end
      end else if (cmd.advance) begin
         idx_in = idx_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         match_ff <= MT_LEAD;
      end else begin
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         match_ff <= match_in;
      end
      ev_ff  <= ev_in;
      idx_ff <= idx_in;
   end

   clad_ram #(
      .WIDTH (8),
      .DEPTH (LINE_CAPACITY)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rsp_event_res = cmd.show_char ? EV_CHAR : ev_ff;
   assign rsp_line_char = cmd.show_char ? rd_data : 8'd0;
   assign rsp_last      = cmd.show_char ? status.last_char : 1'b1;
endmodule

// ===== hw/rtl/clad_ctrl.sv =====
// -----------------------------------------------------------------------------
// clad_ctrl
// sequencer for request intake, single results and line character emission
// -----------------------------------------------------------------------------
module clad_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_mode,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output clad_pkg::cmd_type    cmd,
   input  clad_pkg::status_type status
);
   import clad_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SINGLE = 4'b0010,
      ST_FETCH  = 4'b0100,
      ST_CHAR   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_ABANDON) begin
                  cmd.abandon = 1'b1;
               end else begin
                  cmd.feed = 1'b1;
                  state_in = status.emit_line ? ST_FETCH : ST_SINGLE;
               end
            end
         end
         ST_SINGLE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         ST_FETCH: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHAR;
         end
         ST_CHAR: begin
            rsp_valid     = 1'b1;
            cmd.show_char = 1'b1;
            if (rsp_ready) begin
               if (status.last_char) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_FETCH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== hw/rtl/command_line_assembler_dump_detect.sv =====
// -----------------------------------------------------------------------------
// command_line_assembler_dump_detect
// assembles received text into a command line and flags the dump keyword
// -----------------------------------------------------------------------------
// usage
//   req_bus carries one request per handshake: mode feed with a text byte, or
//   mode abandon, which clears the partial line and gives no result
//   rsp_bus returns results; every fed byte gives one pending result except a
//   line end, which gives unknown (overlong line), pending (empty line), dump,
//   or the stored line one character per result with last on the final one
//   a single result is valid the cycle after its request is taken, and the
//   block takes a new request only once the sink has accepted that result
//   a line sent out character by character fetches each character through
//   the registered read port of the line store before it is offered
//   an abandon request leaves the block ready for another request
//   one request is in flight at a time: req ready is low until its last
//   result has been taken, so a stalled sink holds the result and the input
//   reset clears length, overflow and keyword match at once; the line store
//   needs no clearing pass, only entries below the length are ever read
// -----------------------------------------------------------------------------
module command_line_assembler_dump_detect #(
   parameter int LINE_CAPACITY = 31
) (
   input logic          clock,
   input logic          reset,
   clad_req_if.sink     req_bus,
   clad_rsp_if.source   rsp_bus
);
   import clad_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: request intake, result hold, character loop
   clad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: line store, length, overflow, keyword match, result fields
   clad_dpath #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data_byte (req_bus.data_byte),
      .rsp_event_res (rsp_bus.event_res),
      .rsp_line_char (rsp_bus.line_char),
      .rsp_last      (rsp_bus.last)
   );

   // input is never taken while a result is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request taken while a result is pending");

   // results other than characters carry no character and are final
   a_single_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.event_res != EV_CHAR))
         |-> ((rsp_bus.line_char == 8'd0) && rsp_bus.last))
      else $error("single result with character or without last");

   // an abandon gives no result and the block is ready again
   a_abandon_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && (req_bus.mode == MODE_ABANDON))
         |=> (req_bus.ready && !rsp_bus.valid))
      else $error("abandon produced a result or stalled intake");

   // once the last result is taken the block returns to intake
   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.last) |=> req_bus.ready)
      else $error("not ready after last result");
endmodule
